// ===== design/mesh_frame_tx_queue_controller_core_macros.svh =====
// assertion macros for the mesh transmit queue controller
// used by the top level; expects clk and rst_n in scope
`ifndef MESH_FRAME_TX_QUEUE_CONTROLLER_CORE_MACROS_SVH
`define MESH_FRAME_TX_QUEUE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define MFTQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mftq assertion failed");

// next-cycle implication
`define MFTQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mftq assertion failed");

`endif

// ===== design/mftq_pkg.sv =====
// types, codes and helpers of the mesh transmit queue controller
// no dependencies
`default_nettype none

package mftq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 8;
    localparam int CFG_DATA_W = 16;
    localparam int ACK_WAIT_RESET = 32;

    localparam logic [15:0] BCAST_ADDR = 16'hffff;
    localparam logic [15:0] FCF_BCAST  = 16'h8841;
    localparam logic [15:0] FCF_UCAST  = 16'h8861;

    typedef enum logic [2:0] {
        OP_ENQUEUE = 3'd0,
        OP_PHY_CONFIRM = 3'd1,
        OP_ACK = 3'd2,
        OP_TICK = 3'd3,
        OP_SERVICE = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_TX_REQ = 2'd1,
        EV_CONFIRMED = 2'd2,
        EV_REJECTED = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_SUCCESS = 3'd0,
        ST_CHAN_FAIL = 3'd1,
        ST_PHY_NO_ACK = 3'd2,
        ST_ERROR = 3'd3,
        ST_NET_NO_ACK = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        PH_SEND = 3'd0,
        PH_WAIT_CONF = 3'd1,
        PH_SENT = 3'd2,
        PH_WAIT_ACK = 3'd3,
        PH_CONFIRM = 3'd4
    } phase_t;

    typedef enum logic {
        CFG_OWN_ADDRESS = 1'b0,
        CFG_ACK_WAIT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SETTLE,
        CS_SECOND
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  frame_handle;
        logic [15:0] next_hop_address;
        logic [15:0] network_source;
        logic        ack_request;
        logic [7:0]  network_sequence;
        logic [2:0]  radio_status;
        logic [7:0]  ack_sequence;
    } cmd_beat_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [7:0]  event_handle;
        logic [7:0]  mac_sequence;
        logic [15:0] frame_control;
        logic [2:0]  confirm_status;
        logic        last_result;
    } evt_beat_t;

    typedef struct packed {
        logic       awaited;
        logic [7:0] nseq;
        logic [7:0] handle;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load_second;
    } ctl_t;

    typedef struct packed {
        logic exec_emits;
        logic exec_two;
        logic out_free;
        logic queue_empty;
    } sts_t;

    function automatic status_t map_radio(input logic [2:0] s);
        status_t r;
        if (s <= 3'd2) r = ST_SUCCESS;
        else if (s == 3'd3) r = ST_CHAN_FAIL;
        else if (s == 3'd5) r = ST_PHY_NO_ACK;
        else r = ST_ERROR;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/mftq_ctrl.sv =====
// sequencing state machine of the mesh transmit queue controller
// depends on mftq_pkg
`default_nettype none

module mftq_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire mftq_pkg::sts_t sts,
    output mftq_pkg::ctl_t     ctl
);

    mftq_pkg::ctrl_state_t state_reg;
    mftq_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mftq_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mftq_pkg::CS_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = mftq_pkg::CS_EXEC;
                end
            end
            mftq_pkg::CS_EXEC:
            begin
                if (!sts.exec_emits || sts.out_free)
                begin
                    state_next = sts.exec_two ? mftq_pkg::CS_SETTLE : mftq_pkg::CS_IDLE;
                end
            end
            mftq_pkg::CS_SETTLE:
            begin
                state_next = mftq_pkg::CS_SECOND;
            end
            mftq_pkg::CS_SECOND:
            begin
                if (sts.out_free)
                begin
                    state_next = mftq_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = mftq_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready = 1'b0;
        ctl = '0;
        unique case (state_reg)
            mftq_pkg::CS_IDLE:
            begin
                cmd_ready = 1'b1;
                ctl.capture = cmd_valid;
            end
            mftq_pkg::CS_EXEC:
            begin
                ctl.exec = !sts.exec_emits || sts.out_free;
            end
            mftq_pkg::CS_SETTLE:
            begin
                ctl = '0;
            end
            mftq_pkg::CS_SECOND:
            begin
                ctl.load_second = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/mftq_datapath.sv =====
// queue memory, head tracking, counters and result register
// depends on mftq_pkg; driven by mftq_ctrl
`default_nettype none

module mftq_datapath #(
    parameter int QUEUE_DEPTH = mftq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mftq_pkg::cmd_beat_t            cmd_beat,
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_index,
    input  wire logic [mftq_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           evt_ready,
    output logic                                evt_valid,
    output mftq_pkg::evt_beat_t                 evt_beat,
    input  wire mftq_pkg::ctl_t                 ctl,
    output mftq_pkg::sts_t                      sts
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    mftq_pkg::entry_t mem [QUEUE_DEPTH];
    mftq_pkg::entry_t rd_reg;

    mftq_pkg::cmd_beat_t cmd_reg;
    mftq_pkg::evt_beat_t evt_reg;
    logic                evt_valid_reg;

    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    mftq_pkg::phase_t  phase_reg, phase_next;
    mftq_pkg::status_t result_reg, result_next;
    logic [7:0]        cd_reg, cd_next;
    logic [7:0]        seq_reg, seq_next;
    logic [15:0]       own_addr_reg;
    logic [7:0]        ack_wait_reg;

    logic [SUM_W-1:0]    slot_sum;
    logic [PTR_W-1:0]    slot;
    logic                full, empty, mem_we;
    logic                emits, two;
    mftq_pkg::entry_t    new_entry;
    mftq_pkg::evt_beat_t beat1, beat2;

    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign empty = count_reg == '0;

    assign slot_sum = SUM_W'(rp_reg) + SUM_W'(count_reg);
    assign slot = (slot_sum >= SUM_W'(QUEUE_DEPTH))
        ? PTR_W'(slot_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(slot_sum);

    assign new_entry.handle  = cmd_reg.frame_handle;
    assign new_entry.nseq    = cmd_reg.network_sequence;
    assign new_entry.awaited = cmd_reg.ack_request
        && (cmd_reg.network_source == own_addr_reg);

    always_comb
    begin
        beat1 = '0;
        emits = 1'b0;
        two = 1'b0;
        mem_we = 1'b0;
        phase_next = phase_reg;
        result_next = result_reg;
        cd_next = cd_reg;
        seq_next = seq_reg;
        rp_next = rp_reg;
        count_next = count_reg;
        unique case (cmd_reg.operation)
            mftq_pkg::OP_ENQUEUE:
            begin
                emits = 1'b1;
                beat1.event_handle = cmd_reg.frame_handle;
                if (full)
                begin
                    beat1.event_kind = mftq_pkg::EV_REJECTED;
                end
                else
                begin
                    mem_we = 1'b1;
                    count_next = count_reg + 1'b1;
                    seq_next = seq_reg + 8'd1;
                    beat1.event_kind = mftq_pkg::EV_HEADER;
                    beat1.mac_sequence = seq_next;
                    beat1.frame_control = (cmd_reg.next_hop_address == mftq_pkg::BCAST_ADDR)
                        ? mftq_pkg::FCF_BCAST : mftq_pkg::FCF_UCAST;
                end
            end
            mftq_pkg::OP_PHY_CONFIRM:
            begin
                if (!empty && phase_reg == mftq_pkg::PH_WAIT_CONF)
                begin
                    result_next = mftq_pkg::map_radio(cmd_reg.radio_status);
                    phase_next = mftq_pkg::PH_SENT;
                end
            end
            mftq_pkg::OP_ACK:
            begin
                if (!empty && phase_reg == mftq_pkg::PH_WAIT_ACK
                    && rd_reg.nseq == cmd_reg.ack_sequence)
                begin
                    phase_next = mftq_pkg::PH_CONFIRM;
                end
            end
            mftq_pkg::OP_TICK:
            begin
                if (!empty && phase_reg == mftq_pkg::PH_WAIT_ACK)
                begin
                    cd_next = cd_reg - 8'd1;
                    if (cd_next == 8'd0)
                    begin
                        phase_next = mftq_pkg::PH_CONFIRM;
                        result_next = mftq_pkg::ST_NET_NO_ACK;
                    end
                end
            end
            mftq_pkg::OP_SERVICE:
            begin
                if (!empty)
                begin
                    unique case (phase_reg)
                        mftq_pkg::PH_SEND:
                        begin
                            emits = 1'b1;
                            beat1.event_kind = mftq_pkg::EV_TX_REQ;
                            beat1.event_handle = rd_reg.handle;
                            phase_next = mftq_pkg::PH_WAIT_CONF;
                        end
                        mftq_pkg::PH_SENT:
                        begin
                            if (result_reg == mftq_pkg::ST_SUCCESS && rd_reg.awaited)
                            begin
                                phase_next = mftq_pkg::PH_WAIT_ACK;
                                cd_next = ack_wait_reg;
                            end
                            else
                            begin
                                phase_next = mftq_pkg::PH_CONFIRM;
                            end
                        end
                        mftq_pkg::PH_CONFIRM:
                        begin
                            emits = 1'b1;
                            beat1.event_kind = mftq_pkg::EV_CONFIRMED;
                            beat1.event_handle = rd_reg.handle;
                            beat1.confirm_status = result_reg;
                            rp_next = (rp_reg == PTR_W'(QUEUE_DEPTH - 1))
                                ? '0 : rp_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            result_next = mftq_pkg::ST_SUCCESS;
                            if (count_reg != CNT_W'(1))
                            begin
                                two = 1'b1;
                                phase_next = mftq_pkg::PH_WAIT_CONF;
                            end
                            else
                            begin
                                phase_next = mftq_pkg::PH_SEND;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                emits = 1'b0;
            end
        endcase
        beat1.last_result = !two;
    end

    always_comb
    begin
        beat2 = '0;
        beat2.event_kind = mftq_pkg::EV_TX_REQ;
        beat2.event_handle = rd_reg.handle;
        beat2.last_result = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec && mem_we)
        begin
            mem[slot] <= new_entry;
        end
        rd_reg <= mem[rp_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd_beat;
        end
        if (ctl.exec && emits)
        begin
            evt_reg <= beat1;
        end
        else if (ctl.load_second)
        begin
            evt_reg <= beat2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg <= '0;
            count_reg <= '0;
            phase_reg <= mftq_pkg::PH_SEND;
            result_reg <= mftq_pkg::ST_SUCCESS;
            cd_reg <= '0;
            seq_reg <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                rp_reg <= rp_next;
                count_reg <= count_next;
                phase_reg <= phase_next;
                result_reg <= result_next;
                cd_reg <= cd_next;
                seq_reg <= seq_next;
            end
            if ((ctl.exec && emits) || ctl.load_second)
            begin
                evt_valid_reg <= 1'b1;
            end
            else if (evt_ready)
            begin
                evt_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg <= '0;
            ack_wait_reg <= 8'(mftq_pkg::ACK_WAIT_RESET);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                mftq_pkg::CFG_OWN_ADDRESS: own_addr_reg <= cfg_data;
                mftq_pkg::CFG_ACK_WAIT:    ack_wait_reg <= cfg_data[7:0];
                default:                   own_addr_reg <= own_addr_reg;
            endcase
        end
    end

    assign evt_valid = evt_valid_reg;
    assign evt_beat  = evt_reg;

    assign sts.exec_emits  = emits;
    assign sts.exec_two    = two;
    assign sts.out_free    = !evt_valid_reg || evt_ready;
    assign sts.queue_empty = empty;

endmodule

`default_nettype wire

// ===== design/mesh_frame_tx_queue_controller_core.sv =====
// Mesh transmit queue controller, top level.
// Commands (enqueue, phy confirm, ack, tick, service) enter on the cmd channel,
// events leave on the evt channel, both valid/ready; cfg writes own address
// (index 0) and ack wait ticks (index 1) with no handshake.
// One command is worked at a time: it is taken in the idle state and executed
// in the exec state, which holds while its event beat cannot enter the output
// register. A service pass that confirms the head and starts the next frame
// gives two beats; the second passes through the settle and second states
// because the new head is read from the queue memory through its read
// register, and waits there until the output register is free.
// Events go through one output register: the next command is accepted while
// an event beat waits, and execution holds only when it must produce a beat
// while the register is still full and not being taken.
// Reset empties the queue, zeroes the sequence counter, sets the head to send
// pending and the ack wait to 32 ticks. Queue entries are not cleared.
// Depends on mftq_pkg, mftq_ctrl, mftq_datapath and the assertion macro header.
`default_nettype none

`include "mesh_frame_tx_queue_controller_core_macros.svh"

module mesh_frame_tx_queue_controller_core #(
    parameter int QUEUE_DEPTH = mftq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire mftq_pkg::cmd_beat_t             cmd_beat,
    output logic                                 evt_valid,
    input  wire logic                            evt_ready,
    output mftq_pkg::evt_beat_t                  evt_beat,
    input  wire logic                            cfg_write,
    input  wire logic                            cfg_index,
    input  wire logic [mftq_pkg::CFG_DATA_W-1:0] cfg_data
);

    mftq_pkg::ctl_t ctl;
    mftq_pkg::sts_t sts;
    logic           second_beat_ok;

    mftq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    mftq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_beat  (cmd_beat),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_ready (evt_ready),
        .evt_valid (evt_valid),
        .evt_beat  (evt_beat),
        .ctl       (ctl),
        .sts       (sts)
    );

    assign second_beat_ok = evt_valid && evt_beat.last_result
        && (evt_beat.event_kind == mftq_pkg::EV_TX_REQ);

    `MFTQ_ASSERT_NEXT(a_one_at_a_time, cmd_valid && cmd_ready, !cmd_ready)
    `MFTQ_ASSERT_IMP(a_second_has_head, ctl.load_second, !sts.queue_empty)
    `MFTQ_ASSERT_NEXT(a_second_is_tx, ctl.load_second, second_beat_ok)
    `MFTQ_ASSERT_IMP(a_two_emits, sts.exec_two, sts.exec_emits && !sts.queue_empty)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// testbench for mesh_frame_tx_queue_controller_core: directed and random command beats,
// every event beat checked against a behavioral mirror of the transmit queue
// depends on mftq_pkg and the core RTL
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mftq_pkg::*;

    localparam int QDEPTH = QUEUE_DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS = 55;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RUN_LIMIT_NS = 1_000_000;

    localparam logic [2:0] OP_UNDEFINED = 3'd7;
    localparam logic [2:0] RADIO_SUCCESS = 3'd0;
    localparam logic [2:0] RADIO_SUCCESS_MAX = 3'd2;
    localparam logic [2:0] RADIO_CHAN_BUSY = 3'd3;
    localparam logic [2:0] RADIO_NO_ACK = 3'd5;
    localparam logic [2:0] RADIO_ERROR = 3'd7;

    class tx_queue_mirror;
        entry_t slots [QDEPTH];
        int unsigned rd_ptr;
        int unsigned count;
        phase_t phase;
        status_t result;
        logic [7:0] countdown;
        logic [7:0] mac_seq;
        logic [15:0] own_addr;
        logic [7:0] ack_wait;
        evt_beat_t expected_events [$];
        int unsigned mismatches;

        function new();
            foreach (slots[i])
                slots[i] = '0;
            rd_ptr = 0;
            count = 0;
            phase = PH_SEND;
            result = ST_SUCCESS;
            countdown = '0;
            mac_seq = '0;
            own_addr = '0;
            ack_wait = 8'(ACK_WAIT_RESET);
            mismatches = 0;
        endfunction

        function status_t radio_outcome(logic [2:0] s);
            if (s <= RADIO_SUCCESS_MAX)
                return ST_SUCCESS;
            if (s == RADIO_CHAN_BUSY)
                return ST_CHAN_FAIL;
            if (s == RADIO_NO_ACK)
                return ST_PHY_NO_ACK;
            return ST_ERROR;
        endfunction

        function void add_event(event_t kind, logic [7:0] handle, logic [7:0] seq,
                                logic [15:0] fcf, status_t st);
            evt_beat_t e;
            e.event_kind = kind;
            e.event_handle = handle;
            e.mac_sequence = seq;
            e.frame_control = fcf;
            e.confirm_status = st;
            e.last_result = 1'b0;
            expected_events.push_back(e);
        endfunction

        // notes one accepted command beat, returns 1 if it changed anything
        function bit apply_command(cmd_beat_t c);
            entry_t head;
            phase_t phase_was;
            logic [7:0] countdown_was;
            int unsigned queued_was;
            int unsigned slot;
            evt_beat_t tail;
            head = slots[rd_ptr];
            phase_was = phase;
            countdown_was = countdown;
            queued_was = expected_events.size();
            if (c.operation == OP_ENQUEUE) begin
                if (count >= QDEPTH) begin
                    add_event(EV_REJECTED, c.frame_handle, '0, '0, ST_SUCCESS);
                end
                else begin
                    slot = (rd_ptr + count) % QDEPTH;
                    mac_seq = mac_seq + 8'd1;
                    slots[slot].handle = c.frame_handle;
                    slots[slot].nseq = c.network_sequence;
                    slots[slot].awaited = c.ack_request && (c.network_source == own_addr);
                    count++;
                    add_event(EV_HEADER, c.frame_handle, mac_seq,
                              (c.next_hop_address == BCAST_ADDR) ? FCF_BCAST : FCF_UCAST,
                              ST_SUCCESS);
                end
            end
            else if (count == 0) begin
                // nothing in flight
            end
            else if (c.operation == OP_PHY_CONFIRM) begin
                if (phase == PH_WAIT_CONF) begin
                    result = radio_outcome(c.radio_status);
                    phase = PH_SENT;
                end
            end
            else if (c.operation == OP_ACK) begin
                if (phase == PH_WAIT_ACK && head.nseq == c.ack_sequence)
                    phase = PH_CONFIRM;
            end
            else if (c.operation == OP_TICK) begin
                if (phase == PH_WAIT_ACK) begin
                    countdown = countdown - 8'd1;
                    if (countdown == 8'd0) begin
                        phase = PH_CONFIRM;
                        result = ST_NET_NO_ACK;
                    end
                end
            end
            else if (c.operation == OP_SERVICE) begin
                case (phase)
                    PH_SEND: begin
                        phase = PH_WAIT_CONF;
                        add_event(EV_TX_REQ, head.handle, '0, '0, ST_SUCCESS);
                    end
                    PH_SENT: begin
                        if (result == ST_SUCCESS && head.awaited) begin
                            phase = PH_WAIT_ACK;
                            countdown = ack_wait;
                        end
                        else begin
                            phase = PH_CONFIRM;
                        end
                    end
                    PH_CONFIRM: begin
                        add_event(EV_CONFIRMED, head.handle, '0, '0, result);
                        rd_ptr = (rd_ptr + 1) % QDEPTH;
                        count--;
                        phase = PH_SEND;
                        result = ST_SUCCESS;
                        if (count != 0) begin
                            phase = PH_WAIT_CONF;
                            add_event(EV_TX_REQ, slots[rd_ptr].handle, '0, '0, ST_SUCCESS);
                        end
                    end
                    default: ;
                endcase
            end
            if (expected_events.size() > queued_was) begin
                tail = expected_events.pop_back();
                tail.last_result = 1'b1;
                expected_events.push_back(tail);
            end
            return expected_events.size() != queued_was || phase != phase_was
                || countdown != countdown_was;
        endfunction

        function void report_field(string field, logic [15:0] want, logic [15:0] got);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
        endfunction

        function void match_event(evt_beat_t got);
            evt_beat_t want;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: event beat expected none actual %h", $time, got);
                return;
            end
            want = expected_events.pop_front();
            if (got.event_kind !== want.event_kind)
                report_field("event_kind", want.event_kind, got.event_kind);
            if (got.event_handle !== want.event_handle)
                report_field("event_handle", want.event_handle, got.event_handle);
            if (got.mac_sequence !== want.mac_sequence)
                report_field("mac_sequence", want.mac_sequence, got.mac_sequence);
            if (got.frame_control !== want.frame_control)
                report_field("frame_control", want.frame_control, got.frame_control);
            if (got.confirm_status !== want.confirm_status)
                report_field("confirm_status", want.confirm_status, got.confirm_status);
            if (got.last_result !== want.last_result)
                report_field("last_result", want.last_result, got.last_result);
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_beat_t cmd_beat = '0;
    logic evt_valid;
    logic evt_ready = 1'b0;
    evt_beat_t evt_beat;
    logic cfg_write = 1'b0;
    cfg_index_t cfg_index = CFG_OWN_ADDRESS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tx_queue_mirror mirror;
    int unsigned burst_left = 0;
    bit valid_up = 1'b0;
    bit long_hold_req = 1'b0;
    bit took;

    mesh_frame_tx_queue_controller_core #(
        .QUEUE_DEPTH(QDEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd_beat(cmd_beat),
        .evt_valid(evt_valid),
        .evt_ready(evt_ready),
        .evt_beat(evt_beat),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && evt_valid && evt_ready)
            mirror.match_event(evt_beat);
    end

    initial
    begin : event_sink
        int unsigned cyc;
        int unsigned hold;
        cyc = 0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (long_hold_req) begin
                hold = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end
            if (hold != 0) begin
                hold--;
                evt_ready <= 1'b0;
            end
            else begin
                case ((cyc / 50) % 4)
                    0: evt_ready <= 1'b1;
                    1: evt_ready <= (cyc % 3 == 0);
                    2: evt_ready <= ($urandom_range(0, 1) == 1);
                    default: evt_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic cmd_beat_t mk_cmd(logic [2:0] op, logic [7:0] handle,
                                         logic [15:0] hop, logic [15:0] src, logic ack_req,
                                         logic [7:0] nseq, logic [2:0] radio,
                                         logic [7:0] aseq);
        cmd_beat_t c;
        c.operation = op;
        c.frame_handle = handle;
        c.next_hop_address = hop;
        c.network_source = src;
        c.ack_request = ack_req;
        c.network_sequence = nseq;
        c.radio_status = radio;
        c.ack_sequence = aseq;
        return c;
    endfunction

    // mostly the command the head frame needs next, with random content
    function automatic cmd_beat_t pick_cmd(input int unsigned enq_pct);
        cmd_beat_t c;
        int unsigned roll;
        c.operation = OP_ENQUEUE;
        c.frame_handle = 8'($urandom);
        c.next_hop_address = ($urandom_range(0, 3) == 0) ? BCAST_ADDR : 16'($urandom);
        c.network_source = ($urandom_range(0, 1) == 0) ? mirror.own_addr : 16'($urandom);
        c.ack_request = 1'($urandom);
        c.network_sequence = 8'($urandom);
        c.radio_status = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 2))
                                                     : 3'($urandom);
        c.ack_sequence = 8'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            c.operation = 3'($urandom_range(0, 7));
        end
        else if (mirror.count == 0 || $urandom_range(0, 99) < enq_pct) begin
            c.operation = OP_ENQUEUE;
        end
        else begin
            case (mirror.phase)
                PH_WAIT_CONF: c.operation = OP_PHY_CONFIRM;
                PH_WAIT_ACK: begin
                    roll = $urandom_range(0, 9);
                    if (roll < 3) begin
                        c.operation = OP_ACK;
                        c.ack_sequence = mirror.slots[mirror.rd_ptr].nseq;
                    end
                    else if (roll < 4) begin
                        c.operation = OP_ACK;
                    end
                    else begin
                        c.operation = OP_TICK;
                    end
                end
                default: c.operation = OP_SERVICE;
            endcase
        end
        return c;
    endfunction

    task automatic offer(input cmd_beat_t c, output bit effective);
        int unsigned gap;
        cmd_beat <= c;
        cmd_valid <= 1'b1;
        valid_up = 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        effective = mirror.apply_command(c);
        if (burst_left != 0) begin
            burst_left--;
        end
        else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
            gap = $urandom_range(1, 7);
            cmd_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_and_settle();
        if (valid_up) begin
            cmd_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (mirror.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] own, input logic [7:0] ticks);
        cfg_write <= 1'b1;
        cfg_index <= CFG_OWN_ADDRESS;
        cfg_data <= own;
        @(posedge clk);
        cfg_index <= CFG_ACK_WAIT;
        cfg_data <= {8'h00, ticks};
        @(posedge clk);
        cfg_write <= 1'b0;
        mirror.own_addr = own;
        mirror.ack_wait = ticks;
    endtask

    initial
    begin : stimulus
        logic [15:0] own_sel [6];
        logic [7:0] ticks_sel [6];
        int unsigned enq_pct [6];
        int unsigned done;
        mirror = new();
        own_sel = '{16'h0000, 16'hffff, 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom)};
        ticks_sel = '{8'd1, 8'd3, 8'd255, 8'd2, 8'd7, 8'd0};
        enq_pct = '{30, 60, 20, 45, 12, 35};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(16'h1234, 8'd2);
        offer(mk_cmd(OP_ENQUEUE, 8'h00, BCAST_ADDR, 16'h1234, 1'b1, 8'ha5, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_ENQUEUE, 8'hff, 16'h0000, 16'hffff, 1'b1, 8'h5a, RADIO_ERROR,
                     8'hff), took);
        // commands that do not fit the head's phase, mixed with ones that move it on
        offer(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_PHY_CONFIRM, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_ERROR,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_ACK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'ha5), took);
        offer(mk_cmd(OP_PHY_CONFIRM, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                     RADIO_SUCCESS_MAX, 8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_ACK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h5b), took);
        offer(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_ACK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'ha5), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_PHY_CONFIRM, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                     RADIO_CHAN_BUSY, 8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        // empty queue
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_UNDEFINED, 8'hff, 16'hffff, 16'hffff, 1'b1, 8'hff, RADIO_ERROR,
                     8'hff), took);
        offer(mk_cmd(OP_ENQUEUE, 8'h3c, 16'hfffe, 16'h1234, 1'b1, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_PHY_CONFIRM, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_NO_ACK,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        // ack timeout
        offer(mk_cmd(OP_ENQUEUE, 8'h81, 16'h7fff, 16'h1234, 1'b1, 8'hff, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_PHY_CONFIRM, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);
        offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00, RADIO_SUCCESS,
                     8'h00), took);

        for (int p = 0; p < 6; p++) begin
            drain_and_settle();
            if (p == 5) begin
                while (mirror.count != 0)
                    offer(pick_cmd(0), took);
                drain_and_settle();
            end
            set_config(own_sel[p], ticks_sel[p]);
            if (p == 5) begin
                // zero wait ticks: countdown wraps, 256 ticks to time out
                offer(mk_cmd(OP_ENQUEUE, 8'h42, 16'h0001, own_sel[p], 1'b1, 8'h99,
                             RADIO_SUCCESS, 8'h00), took);
                offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                             RADIO_SUCCESS, 8'h00), took);
                offer(mk_cmd(OP_PHY_CONFIRM, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                             RADIO_SUCCESS, 8'h00), took);
                offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                             RADIO_SUCCESS, 8'h00), took);
                repeat (255)
                    offer(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                                 RADIO_SUCCESS, 8'h00), took);
                offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                             RADIO_SUCCESS, 8'h00), took);
                offer(mk_cmd(OP_TICK, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                             RADIO_SUCCESS, 8'h00), took);
                offer(mk_cmd(OP_SERVICE, 8'h00, 16'h0000, 16'h0000, 1'b0, 8'h00,
                             RADIO_SUCCESS, 8'h00), took);
            end
            if (p == 1)
                long_hold_req = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                offer(pick_cmd(enq_pct[p]), took);
                if (took)
                    done++;
            end
        end

        drain_and_settle();
        if (mirror.mismatches == 0 && mirror.expected_events.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/mftq_pkg.sv
design/mftq_ctrl.sv
design/mftq_datapath.sv
design/mesh_frame_tx_queue_controller_core.sv
bench/tb_top.sv
